>>> rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types, codes and defaults of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

	localparam int HEAP_BYTES_DEF  = 8 << 20;
	localparam int ALIGN_BYTES_DEF = 16;
	localparam int MAX_FREE_DEF    = 64;
	localparam int MAX_LIVE_DEF    = 64;

	localparam logic [47:0] HEAP_BASE_RST = 48'd4096;

	// register index, taken from paddr[3]
	localparam logic REG_HEAP_BASE = 1'b0;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_TOO_BIG  = 3'd2;
	localparam logic [2:0] ST_DBL_FREE = 3'd3;
	localparam logic [2:0] ST_OUTSIDE  = 3'd4;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	// datapath operations, one per cycle
	localparam logic [5:0] OP_IDLE        = 6'd0;
	localparam logic [5:0] OP_INIT        = 6'd1;
	localparam logic [5:0] OP_LOAD        = 6'd2;
	localparam logic [5:0] OP_IDX_CLR     = 6'd3;
	localparam logic [5:0] OP_STATUS      = 6'd4;
	localparam logic [5:0] OP_FAIL        = 6'd5;
	localparam logic [5:0] OP_FS_RD       = 6'd6;
	localparam logic [5:0] OP_FS_CMP      = 6'd7;
	localparam logic [5:0] OP_FS_SPLIT    = 6'd8;
	localparam logic [5:0] OP_FS_REMOVE   = 6'd9;
	localparam logic [5:0] OP_SHD_RD      = 6'd10;
	localparam logic [5:0] OP_SHD_WR      = 6'd11;
	localparam logic [5:0] OP_SHD_END     = 6'd12;
	localparam logic [5:0] OP_APPEND      = 6'd13;
	localparam logic [5:0] OP_FD_RD       = 6'd14;
	localparam logic [5:0] OP_FD_CMP      = 6'd15;
	localparam logic [5:0] OP_FL_RD       = 6'd16;
	localparam logic [5:0] OP_FL_CMP      = 6'd17;
	localparam logic [5:0] OP_RL_WHOLE    = 6'd18;
	localparam logic [5:0] OP_RL_TAIL     = 6'd19;
	localparam logic [5:0] OP_RL_RD       = 6'd20;
	localparam logic [5:0] OP_RL_CMP      = 6'd21;
	localparam logic [5:0] OP_RL_BOTH     = 6'd22;
	localparam logic [5:0] OP_RL_PREV     = 6'd23;
	localparam logic [5:0] OP_RL_NEXT     = 6'd24;
	localparam logic [5:0] OP_SHU_INIT    = 6'd25;
	localparam logic [5:0] OP_SHU_RD      = 6'd26;
	localparam logic [5:0] OP_SHU_WR      = 6'd27;
	localparam logic [5:0] OP_SHU_END     = 6'd28;
	localparam logic [5:0] OP_FREE_DONE   = 6'd29;
	localparam logic [5:0] OP_SHRINK_DONE = 6'd30;
	localparam logic [5:0] OP_LR_RD       = 6'd31;
	localparam logic [5:0] OP_LR_WR       = 6'd32;
	localparam logic [5:0] OP_UNDO        = 6'd33;
	localparam logic [5:0] OP_EMIT        = 6'd34;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [47:0] addr;
		logic [31:0] size;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] result_addr;
		logic [31:0] live_allocs;
		logic [47:0] live_bytes;
		logic [31:0] total_allocs;
		logic [47:0] total_bytes;
		logic [31:0] failed_allocs;
		logic [47:0] failed_bytes;
		logic [47:0] lowest_addr;
		logic [47:0] highest_end;
	} rsp_t;

	typedef struct packed {
		logic [5:0] op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       size_zero;
		logic       addr_zero;
		logic       too_large;
		logic       live_full;
		logic       idx_end;
		logic       fit;
		logic       exact;
		logic       fd_hit;
		logic       out_range;
		logic       lidx_end;
		logic       fl_hit;
		logic       grow;
		logic       tail;
		logic       rl_le;
		logic       mp;
		logic       mn;
		logic       free_full;
		logic       shd_end;
		logic       shu_end;
		logic       out_free;
	} dp_sts_t;

endpackage

>>> rtl/first_fit_extent_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top
// First-fit heap allocator with coalescing free table and live table.
// ----------------------------------------------------------------------------
// Requests (allocate, free, resize) arrive on the req channel and each gives
// exactly one result transfer on the rsp channel, with status, granted address
// and the statistics counters as they stand after the request.
// heap_base sits at byte address 0 of the APB port (64-bit data); writing it
// while idle empties the live table and makes the heap one free extent.
// One request is worked at a time. Its run time grows with the scans of the
// free and live table RAMs, where each entry is read and then compared, and
// with the entries shifted in the free table; an unknown command or a free of
// null takes no scan. req_ready is high while the sequencer is idle, also
// while a result still waits; if rsp stalls, the finished request holds until
// the result register frees up. After reset the sequencer first loads the
// initial extent (base 4096), then requests are taken.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_top #(
	parameter int HEAP_BYTES  = ffea_pkg::HEAP_BYTES_DEF,
	parameter int ALIGN_BYTES = ffea_pkg::ALIGN_BYTES_DEF,
	parameter int MAX_FREE    = ffea_pkg::MAX_FREE_DEF,
	parameter int MAX_LIVE    = ffea_pkg::MAX_LIVE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ffea_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ffea_pkg::rsp_t   rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import ffea_pkg::*;

	dp_cmd_t     dcmd;
	dp_sts_t     sts;
	logic        cfg_we;
	logic [47:0] heap_base;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[3] == REG_HEAP_BASE);
	assign prdata = (paddr[3] == REG_HEAP_BASE) ? {16'd0, heap_base} : 64'd0;

	ffea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.dcmd      (dcmd),
		.sts       (sts)
	);

	ffea_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.ALIGN_BYTES (ALIGN_BYTES),
		.MAX_FREE    (MAX_FREE),
		.MAX_LIVE    (MAX_LIVE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (pwdata[47:0]),
		.heap_base (heap_base),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule

>>> rtl/ffea_ram.sv
// ----------------------------------------------------------------------------
// ffea_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/ffea_ctrl.sv
// ----------------------------------------------------------------------------
// ffea_ctrl
// Sequencer of the allocator: walks allocate, free and resize through the
// datapath one operation per cycle, waiting while the result register is full.
// ----------------------------------------------------------------------------
module ffea_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output ffea_pkg::dp_cmd_t dcmd,
	input  ffea_pkg::dp_sts_t sts
);
	import ffea_pkg::*;

	localparam logic [4:0] S_INIT  = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DISP  = 5'd2;
	localparam logic [4:0] S_ACHK  = 5'd3;
	localparam logic [4:0] S_FSRD  = 5'd4;
	localparam logic [4:0] S_FSCMP = 5'd5;
	localparam logic [4:0] S_FSSPL = 5'd6;
	localparam logic [4:0] S_FSREM = 5'd7;
	localparam logic [4:0] S_SHD   = 5'd8;
	localparam logic [4:0] S_SHDW  = 5'd9;
	localparam logic [4:0] S_APP   = 5'd10;
	localparam logic [4:0] S_FDRD  = 5'd11;
	localparam logic [4:0] S_FDCMP = 5'd12;
	localparam logic [4:0] S_FDRNG = 5'd13;
	localparam logic [4:0] S_FLRD  = 5'd14;
	localparam logic [4:0] S_FLCMP = 5'd15;
	localparam logic [4:0] S_FLHIT = 5'd16;
	localparam logic [4:0] S_RLW   = 5'd17;
	localparam logic [4:0] S_RLT   = 5'd18;
	localparam logic [4:0] S_RLRD  = 5'd19;
	localparam logic [4:0] S_RLCMP = 5'd20;
	localparam logic [4:0] S_RLDEC = 5'd21;
	localparam logic [4:0] S_SHU   = 5'd22;
	localparam logic [4:0] S_SHUW  = 5'd23;
	localparam logic [4:0] S_RLOK  = 5'd24;
	localparam logic [4:0] S_RLBAD = 5'd25;
	localparam logic [4:0] S_LRRD  = 5'd26;
	localparam logic [4:0] S_LRWR  = 5'd27;
	localparam logic [4:0] S_UNDO  = 5'd28;
	localparam logic [4:0] S_UFAIL = 5'd29;
	localparam logic [4:0] S_FIN   = 5'd30;

	localparam logic [1:0] M_ALLOC  = 2'd0;
	localparam logic [1:0] M_FREE   = 2'd1;
	localparam logic [1:0] M_SHRINK = 2'd2;
	localparam logic [1:0] M_MOVE   = 2'd3;

	logic [4:0] state_q, state_n;
	logic [1:0] mode_q, mode_n;
	logic       rel_q, rel_n;

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			mode_q  <= M_ALLOC;
			rel_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			mode_q  <= mode_n;
			rel_q   <= rel_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		mode_n    = mode_q;
		rel_n     = rel_q;
		dcmd.op   = OP_IDLE;
		dcmd.code = ST_OK;
		case (state_q)
			S_INIT: begin
				dcmd.op = OP_INIT;
				state_n = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					dcmd.op = OP_LOAD;
					rel_n   = 1'b0;
					state_n = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.cmd)
					CMD_ALLOC: begin
						mode_n  = M_ALLOC;
						state_n = S_ACHK;
					end
					CMD_FREE: begin
						mode_n  = M_FREE;
						state_n = sts.addr_zero ? S_FIN : S_FDRD;
					end
					CMD_RESIZE: begin
						if (sts.size_zero) begin
							mode_n  = M_FREE;
							state_n = sts.addr_zero ? S_FIN : S_FDRD;
						end else if (sts.addr_zero) begin
							mode_n  = M_ALLOC;
							state_n = S_ACHK;
						end else begin
							mode_n  = M_SHRINK;
							state_n = S_FLRD;
						end
					end
					default: state_n = S_FIN;
				endcase
			end
			S_ACHK: begin
				if (sts.too_large) begin
					dcmd.op   = OP_FAIL;
					dcmd.code = ST_TOO_BIG;
					state_n   = S_FIN;
				end else if (sts.live_full) begin
					dcmd.op   = OP_FAIL;
					dcmd.code = ST_FULL;
					state_n   = S_FIN;
				end else begin
					dcmd.op = OP_IDX_CLR;
					state_n = S_FSRD;
				end
			end
			S_FSRD: begin
				if (sts.idx_end) begin
					dcmd.op   = OP_FAIL;
					dcmd.code = ST_NO_SPACE;
					state_n   = S_FIN;
				end else begin
					dcmd.op = OP_FS_RD;
					state_n = S_FSCMP;
				end
			end
			S_FSCMP: begin
				dcmd.op = OP_FS_CMP;
				if (!sts.fit) begin
					state_n = S_FSRD;
				end else if (sts.exact) begin
					state_n = S_FSREM;
				end else begin
					state_n = S_FSSPL;
				end
			end
			S_FSSPL: begin
				dcmd.op = OP_FS_SPLIT;
				state_n = S_APP;
			end
			S_FSREM: begin
				dcmd.op = OP_FS_REMOVE;
				state_n = S_SHD;
			end
			S_SHD: begin
				if (sts.shd_end) begin
					dcmd.op = OP_SHD_END;
					state_n = rel_q ? S_RLOK : S_APP;
				end else begin
					dcmd.op = OP_SHD_RD;
					state_n = S_SHDW;
				end
			end
			S_SHDW: begin
				dcmd.op = OP_SHD_WR;
				state_n = S_SHD;
			end
			S_APP: begin
				dcmd.op = OP_APPEND;
				state_n = (mode_q == M_MOVE) ? S_RLW : S_FIN;
			end
			S_FDRD: begin
				if (sts.idx_end) begin
					state_n = S_FDRNG;
				end else begin
					dcmd.op = OP_FD_RD;
					state_n = S_FDCMP;
				end
			end
			S_FDCMP: begin
				if (sts.fd_hit) begin
					dcmd.op   = OP_STATUS;
					dcmd.code = ST_DBL_FREE;
					state_n   = S_FIN;
				end else begin
					dcmd.op = OP_FD_CMP;
					state_n = S_FDRD;
				end
			end
			S_FDRNG: begin
				if (sts.out_range) begin
					dcmd.op   = OP_STATUS;
					dcmd.code = ST_OUTSIDE;
					state_n   = S_FIN;
				end else begin
					state_n = S_FLRD;
				end
			end
			S_FLRD: begin
				if (sts.lidx_end) begin
					dcmd.op   = OP_STATUS;
					dcmd.code = ST_NOT_ALLOC;
					state_n   = S_FIN;
				end else begin
					dcmd.op = OP_FL_RD;
					state_n = S_FLCMP;
				end
			end
			S_FLCMP: begin
				dcmd.op = OP_FL_CMP;
				state_n = sts.fl_hit ? S_FLHIT : S_FLRD;
			end
			S_FLHIT: begin
				if (mode_q == M_FREE) begin
					state_n = S_RLW;
				end else if (sts.grow) begin
					mode_n  = M_MOVE;
					state_n = S_ACHK;
				end else if (sts.tail) begin
					state_n = S_RLT;
				end else begin
					state_n = S_RLOK;
				end
			end
			S_RLW: begin
				dcmd.op = OP_RL_WHOLE;
				rel_n   = 1'b1;
				state_n = S_RLRD;
			end
			S_RLT: begin
				dcmd.op = OP_RL_TAIL;
				rel_n   = 1'b1;
				state_n = S_RLRD;
			end
			S_RLRD: begin
				dcmd.op = OP_RL_RD;
				state_n = sts.idx_end ? S_RLDEC : S_RLCMP;
			end
			S_RLCMP: begin
				dcmd.op = OP_RL_CMP;
				state_n = sts.rl_le ? S_RLRD : S_RLDEC;
			end
			S_RLDEC: begin
				if (sts.mp && sts.mn) begin
					dcmd.op = OP_RL_BOTH;
					state_n = S_SHD;
				end else if (sts.mp) begin
					dcmd.op = OP_RL_PREV;
					state_n = S_RLOK;
				end else if (sts.mn) begin
					dcmd.op = OP_RL_NEXT;
					state_n = S_RLOK;
				end else if (sts.free_full) begin
					state_n = S_RLBAD;
				end else begin
					dcmd.op = OP_SHU_INIT;
					state_n = S_SHU;
				end
			end
			S_SHU: begin
				if (sts.shu_end) begin
					dcmd.op = OP_SHU_END;
					state_n = S_RLOK;
				end else begin
					dcmd.op = OP_SHU_RD;
					state_n = S_SHUW;
				end
			end
			S_SHUW: begin
				dcmd.op = OP_SHU_WR;
				state_n = S_SHU;
			end
			S_RLOK: begin
				if (mode_q == M_SHRINK) begin
					dcmd.op = OP_SHRINK_DONE;
					state_n = S_FIN;
				end else begin
					dcmd.op = OP_FREE_DONE;
					state_n = S_LRRD;
				end
			end
			S_RLBAD: begin
				if (mode_q == M_MOVE) begin
					state_n = S_UNDO;
				end else begin
					dcmd.op   = OP_STATUS;
					dcmd.code = ST_FULL;
					state_n   = S_FIN;
				end
			end
			S_LRRD: begin
				dcmd.op = OP_LR_RD;
				state_n = S_LRWR;
			end
			S_LRWR: begin
				dcmd.op = OP_LR_WR;
				state_n = S_FIN;
			end
			S_UNDO: begin
				dcmd.op = OP_UNDO;
				state_n = S_UFAIL;
			end
			S_UFAIL: begin
				dcmd.op   = OP_FAIL;
				dcmd.code = ST_FULL;
				state_n   = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					dcmd.op = OP_EMIT;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule

>>> rtl/ffea_dp.sv
// ----------------------------------------------------------------------------
// ffea_dp
// Allocator datapath: free and live tables in RAM, scan and shift indexes,
// release scratch registers, statistics and the result register.
// ----------------------------------------------------------------------------
module ffea_dp #(
	parameter int HEAP_BYTES  = ffea_pkg::HEAP_BYTES_DEF,
	parameter int ALIGN_BYTES = ffea_pkg::ALIGN_BYTES_DEF,
	parameter int MAX_FREE    = ffea_pkg::MAX_FREE_DEF,
	parameter int MAX_LIVE    = ffea_pkg::MAX_LIVE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffea_pkg::dp_cmd_t dcmd,
	output ffea_pkg::dp_sts_t sts,
	input  ffea_pkg::req_t    req,
	input  logic              cfg_we,
	input  logic [47:0]       cfg_data,
	output logic [47:0]       heap_base,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ffea_pkg::rsp_t    rsp
);
	import ffea_pkg::*;

	// ALIGN_BYTES is a power of two
	localparam int SH    = $clog2(ALIGN_BYTES);
	localparam int LEN_W = $clog2(HEAP_BYTES + 1);
	localparam int FIW   = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
	localparam int FCW   = $clog2(MAX_FREE + 1);
	localparam int LIW   = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
	localparam int LCW   = $clog2(MAX_LIVE + 1);
	localparam int FE_W  = 48 + LEN_W;
	localparam int LE_W  = 48 + 2 * LEN_W;
	localparam logic [LEN_W-1:0] HEAP_LEN = LEN_W'(HEAP_BYTES);

	logic [47:0]      base_q;
	logic [1:0]       cmd_q;
	logic [47:0]      addr_q;
	logic [31:0]      size_q;
	logic [FCW-1:0]   fcnt_q, idx_q, sk_q;
	logic [LCW-1:0]   lcnt_q, lidx_q;
	logic [FIW-1:0]   aj_q;
	logic [LIW-1:0]   li_q;
	logic [47:0]      a_start_q;
	logic [LEN_W-1:0] a_len_q;
	logic [LEN_W-1:0] oreq_q, oblk_q;
	logic [47:0]      rs_q, pst_q, nst_q;
	logic [LEN_W-1:0] rl_q, plen_q, nlen_q;
	logic             pv_q, nv_q;
	logic [2:0]       res_status_q;
	logic [47:0]      res_addr_q;

	logic [31:0] live_q, total_q, fail_q;
	logic [47:0] lbytes_q, tbytes_q, fbytes_q, low_q, high_q;
	logic [31:0] sv_live_q, sv_total_q;
	logic [47:0] sv_lbytes_q, sv_tbytes_q, sv_low_q, sv_high_q;

	logic       out_valid_q;
	rsp_t       out_q;

	// RAM ports
	logic             f_we, l_we;
	logic [FIW-1:0]   f_waddr, f_raddr;
	logic [LIW-1:0]   l_waddr, l_raddr;
	logic [FE_W-1:0]  f_wdata, f_rdata;
	logic [LE_W-1:0]  l_wdata, l_rdata;

	logic [47:0]      f_rstart, l_rstart;
	logic [LEN_W-1:0] f_rlen, l_rreq, l_rblk;
	logic [32:0]      blk_w;
	logic [FCW-1:0]   idx_m1, sk_p1, sk_m1;
	logic [LCW-1:0]   lcnt_m1;
	logic [47:0]      o_w;
	logic [48:0]      prev_end, next_cut, next_off;
	logic [32:0]      total_sum, fail_sum;
	logic [48:0]      tb_sum, fb_sum, end_sum;
	logic [47:0]      end_v;

	assign f_rstart = f_rdata[FE_W-1:LEN_W];
	assign f_rlen   = f_rdata[LEN_W-1:0];
	assign l_rstart = l_rdata[LE_W-1:2*LEN_W];
	assign l_rreq   = l_rdata[2*LEN_W-1:LEN_W];
	assign l_rblk   = l_rdata[LEN_W-1:0];

	assign blk_w   = (33'(size_q >> SH) + 33'd1) << SH;
	assign idx_m1  = idx_q - FCW'(1);
	assign sk_p1   = sk_q + FCW'(1);
	assign sk_m1   = sk_q - FCW'(1);
	assign lcnt_m1 = lcnt_q - LCW'(1);
	assign o_w     = rs_q - base_q;
	assign prev_end = {1'b0, pst_q - base_q} + 49'(plen_q);
	assign next_cut = {1'b0, o_w} + 49'(rl_q);
	assign next_off = {1'b0, nst_q - base_q};

	assign total_sum = {1'b0, total_q} + 33'd1;
	assign fail_sum  = {1'b0, fail_q} + 33'd1;
	assign tb_sum    = {1'b0, tbytes_q} + 49'(size_q);
	assign fb_sum    = {1'b0, fbytes_q} + 49'(size_q);
	assign end_sum   = {1'b0, a_start_q} + 49'(size_q);
	assign end_v     = end_sum[48] ? '1 : end_sum[47:0];

	assign heap_base = base_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// status toward the sequencer
	always_comb begin
		sts.cmd       = cmd_q;
		sts.size_zero = (size_q == '0);
		sts.addr_zero = (addr_q == '0);
		sts.too_large = (size_q >= 32'(HEAP_BYTES));
		sts.live_full = (lcnt_q >= LCW'(MAX_LIVE));
		sts.idx_end   = (idx_q == fcnt_q);
		sts.fit       = (33'(f_rlen) >= blk_w);
		sts.exact     = (33'(f_rlen) == blk_w);
		sts.fd_hit    = (f_rstart == addr_q);
		sts.out_range = ((addr_q - base_q) >= 48'(HEAP_BYTES));
		sts.lidx_end  = (lidx_q == lcnt_q);
		sts.fl_hit    = (l_rstart == addr_q);
		sts.grow      = (blk_w > 33'(oblk_q));
		sts.tail      = (blk_w < 33'(oblk_q));
		sts.rl_le     = ((f_rstart - base_q) <= o_w);
		sts.mp        = pv_q && (prev_end == {1'b0, o_w});
		sts.mn        = nv_q && (next_cut == next_off);
		sts.free_full = (fcnt_q >= FCW'(MAX_FREE));
		sts.shd_end   = (sk_p1 >= fcnt_q);
		sts.shu_end   = (sk_q <= idx_q);
		sts.out_free  = !out_valid_q || rsp_ready;
	end

	// table RAM ports
	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q[FIW-1:0];
		f_wdata = {pst_q, plen_q + rl_q};
		f_raddr = idx_q[FIW-1:0];
		l_we    = 1'b0;
		l_waddr = li_q;
		l_wdata = l_rdata;
		l_raddr = lidx_q[LIW-1:0];
		case (dcmd.op)
			OP_SHD_RD: f_raddr = sk_p1[FIW-1:0];
			OP_SHU_RD: f_raddr = sk_m1[FIW-1:0];
			OP_LR_RD:  l_raddr = lcnt_m1[LIW-1:0];
			OP_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {base_q, HEAP_LEN};
			end
			OP_FS_SPLIT: begin
				f_we    = 1'b1;
				f_waddr = aj_q;
				f_wdata = {a_start_q + 48'(blk_w), a_len_q - blk_w[LEN_W-1:0]};
			end
			OP_SHD_WR, OP_SHU_WR: begin
				f_we    = 1'b1;
				f_waddr = sk_q[FIW-1:0];
				f_wdata = f_rdata;
			end
			OP_RL_BOTH: begin
				f_we    = 1'b1;
				f_waddr = idx_m1[FIW-1:0];
				f_wdata = {pst_q, plen_q + rl_q + nlen_q};
			end
			OP_RL_PREV: begin
				f_we    = 1'b1;
				f_waddr = idx_m1[FIW-1:0];
				f_wdata = {pst_q, plen_q + rl_q};
			end
			OP_RL_NEXT: begin
				f_we    = 1'b1;
				f_waddr = idx_q[FIW-1:0];
				f_wdata = {rs_q, nlen_q + rl_q};
			end
			OP_SHU_END: begin
				f_we    = 1'b1;
				f_waddr = idx_q[FIW-1:0];
				f_wdata = {rs_q, rl_q};
			end
			OP_UNDO: begin
				f_we    = 1'b1;
				f_waddr = aj_q;
				f_wdata = {a_start_q, a_len_q};
			end
			OP_APPEND: begin
				l_we    = 1'b1;
				l_waddr = lcnt_q[LIW-1:0];
				l_wdata = {a_start_q, size_q[LEN_W-1:0], blk_w[LEN_W-1:0]};
			end
			OP_SHRINK_DONE: begin
				l_we    = 1'b1;
				l_waddr = li_q;
				l_wdata = {addr_q, size_q[LEN_W-1:0], blk_w[LEN_W-1:0]};
			end
			OP_LR_WR: begin
				l_we    = 1'b1;
				l_waddr = li_q;
				l_wdata = l_rdata;
			end
			default: ;
		endcase
		// a base write rebuilds the heap as one extent
		if (cfg_we) begin
			f_we    = 1'b1;
			f_waddr = '0;
			f_wdata = {cfg_data, HEAP_LEN};
		end
	end

	ffea_ram #(.WIDTH(FE_W), .DEPTH(MAX_FREE)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	ffea_ram #(.WIDTH(LE_W), .DEPTH(MAX_LIVE)) u_live_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	// control state: base, counts, statistics, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= HEAP_BASE_RST;
			fcnt_q      <= FCW'(1);
			lcnt_q      <= '0;
			live_q      <= '0;
			lbytes_q    <= '0;
			total_q     <= '0;
			tbytes_q    <= '0;
			fail_q      <= '0;
			fbytes_q    <= '0;
			low_q       <= '1;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (dcmd.op)
				OP_INIT: begin
					fcnt_q <= FCW'(1);
					lcnt_q <= '0;
				end
				OP_FAIL: begin
					fail_q   <= fail_sum[32] ? '1 : fail_sum[31:0];
					fbytes_q <= fb_sum[48] ? '1 : fb_sum[47:0];
				end
				OP_SHD_END: fcnt_q <= fcnt_q - FCW'(1);
				OP_SHU_END: fcnt_q <= fcnt_q + FCW'(1);
				OP_APPEND: begin
					lcnt_q   <= lcnt_q + LCW'(1);
					total_q  <= total_sum[32] ? '1 : total_sum[31:0];
					tbytes_q <= tb_sum[48] ? '1 : tb_sum[47:0];
					live_q   <= live_q + 32'd1;
					lbytes_q <= lbytes_q + 48'(size_q);
					if (a_start_q < low_q) begin
						low_q <= a_start_q;
					end
					if (end_v > high_q) begin
						high_q <= end_v;
					end
				end
				OP_FREE_DONE: begin
					live_q   <= live_q - 32'd1;
					lbytes_q <= lbytes_q - 48'(oreq_q);
				end
				OP_SHRINK_DONE: lbytes_q <= lbytes_q - 48'(oreq_q) + 48'(size_q);
				OP_LR_WR: lcnt_q <= lcnt_m1;
				OP_UNDO: begin
					lcnt_q   <= lcnt_m1;
					live_q   <= sv_live_q;
					lbytes_q <= sv_lbytes_q;
					total_q  <= sv_total_q;
					tbytes_q <= sv_tbytes_q;
					low_q    <= sv_low_q;
					high_q   <= sv_high_q;
				end
				OP_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
			if (cfg_we) begin
				base_q <= cfg_data;
				fcnt_q <= FCW'(1);
				lcnt_q <= '0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_LOAD: begin
				cmd_q        <= req.cmd;
				addr_q       <= req.addr;
				size_q       <= req.size;
				idx_q        <= '0;
				lidx_q       <= '0;
				res_status_q <= ST_OK;
				res_addr_q   <= '0;
			end
			OP_IDX_CLR: idx_q <= '0;
			OP_STATUS, OP_FAIL: res_status_q <= dcmd.code;
			OP_FS_CMP: begin
				aj_q      <= idx_q[FIW-1:0];
				a_start_q <= f_rstart;
				a_len_q   <= f_rlen;
				if (!sts.fit) begin
					idx_q <= idx_q + FCW'(1);
				end
			end
			OP_FS_REMOVE, OP_RL_BOTH: sk_q <= idx_q;
			OP_SHD_WR: sk_q <= sk_p1;
			OP_SHU_INIT: sk_q <= fcnt_q;
			OP_SHU_WR: sk_q <= sk_m1;
			OP_APPEND: begin
				res_addr_q  <= a_start_q;
				sv_live_q   <= live_q;
				sv_lbytes_q <= lbytes_q;
				sv_total_q  <= total_q;
				sv_tbytes_q <= tbytes_q;
				sv_low_q    <= low_q;
				sv_high_q   <= high_q;
			end
			OP_FD_CMP: idx_q <= idx_q + FCW'(1);
			OP_FL_CMP: begin
				li_q   <= lidx_q[LIW-1:0];
				oreq_q <= l_rreq;
				oblk_q <= l_rblk;
				if (!sts.fl_hit) begin
					lidx_q <= lidx_q + LCW'(1);
				end
			end
			OP_RL_WHOLE: begin
				rs_q  <= addr_q;
				rl_q  <= oblk_q;
				idx_q <= '0;
				pv_q  <= 1'b0;
			end
			OP_RL_TAIL: begin
				rs_q  <= addr_q + 48'(blk_w);
				rl_q  <= oblk_q - blk_w[LEN_W-1:0];
				idx_q <= '0;
				pv_q  <= 1'b0;
			end
			OP_RL_RD: nv_q <= 1'b0;
			OP_RL_CMP: begin
				if (sts.rl_le) begin
					pst_q  <= f_rstart;
					plen_q <= f_rlen;
					pv_q   <= 1'b1;
					idx_q  <= idx_q + FCW'(1);
				end else begin
					nst_q  <= f_rstart;
					nlen_q <= f_rlen;
					nv_q   <= 1'b1;
				end
			end
			OP_SHRINK_DONE: res_addr_q <= addr_q;
			OP_EMIT: begin
				out_q.status        <= res_status_q;
				out_q.result_addr   <= (res_status_q == ST_OK) ? res_addr_q : '0;
				out_q.live_allocs   <= live_q;
				out_q.live_bytes    <= lbytes_q;
				out_q.total_allocs  <= total_q;
				out_q.total_bytes   <= tbytes_q;
				out_q.failed_allocs <= fail_q;
				out_q.failed_bytes  <= fbytes_q;
				out_q.lowest_addr   <= low_q;
				out_q.highest_end   <= high_q;
			end
			default: ;
		endcase
	end
endmodule

>>> sim/ffea_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffea_checker
// Watches the request, result and register ports of the extent allocator,
// keeps its own copy of the free table, live table and counters, predicts
// one result per accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module ffea_checker #(
	parameter int HEAP  = ffea_pkg::HEAP_BYTES_DEF,
	parameter int ALIGN = ffea_pkg::ALIGN_BYTES_DEF,
	parameter int NFREE = ffea_pkg::MAX_FREE_DEF,
	parameter int NLIVE = ffea_pkg::MAX_LIVE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  ffea_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  ffea_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [63:0]     pwdata,
	input  logic            pready,
	output int              n_errors,
	output int              n_pending
);
	import ffea_pkg::*;

	localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] M32 = 64'hFFFF_FFFF;

	// counter slots
	localparam int CNT_LIVE   = 0;
	localparam int CNT_LBYTES = 1;
	localparam int CNT_TOTAL  = 2;
	localparam int CNT_TBYTES = 3;
	localparam int CNT_FAIL   = 4;
	localparam int CNT_FBYTES = 5;
	localparam int CNT_LOW    = 6;
	localparam int CNT_HIGH   = 7;

	logic [47:0] heap_base;
	logic [47:0] ext_start[NFREE];
	logic [31:0] ext_len[NFREE];
	int          ext_n;
	logic [47:0] blk_start[NLIVE];
	logic [31:0] blk_req[NLIVE];
	logic [31:0] blk_len[NLIVE];
	int          blk_n;
	logic [63:0] cnt[8];

	logic [47:0] sv_ext_start[NFREE];
	logic [31:0] sv_ext_len[NFREE];
	int          sv_ext_n;
	logic [47:0] sv_blk_start[NLIVE];
	logic [31:0] sv_blk_req[NLIVE];
	logic [31:0] sv_blk_len[NLIVE];
	int          sv_blk_n;
	logic [63:0] sv_cnt[8];

	rsp_t expected_rsp[$];

	assign n_pending = expected_rsp.size();

	function automatic logic [63:0] heap_off(logic [47:0] a);
		logic [47:0] d;
		d = a - heap_base;
		return {16'd0, d};
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] x, logic [63:0] y, logic [63:0] top);
		return (y > top - x) ? top : x + y;
	endfunction

	function automatic void reload_tables();
		ext_start[0] = heap_base;
		ext_len[0] = HEAP;
		ext_n = 1;
		blk_n = 0;
	endfunction

	function automatic void snapshot(bit back);
		for (int i = 0; i < NFREE; i++) begin
			if (back) begin
				ext_start[i] = sv_ext_start[i];
				ext_len[i] = sv_ext_len[i];
			end else begin
				sv_ext_start[i] = ext_start[i];
				sv_ext_len[i] = ext_len[i];
			end
		end
		for (int i = 0; i < NLIVE; i++) begin
			if (back) begin
				blk_start[i] = sv_blk_start[i];
				blk_req[i] = sv_blk_req[i];
				blk_len[i] = sv_blk_len[i];
			end else begin
				sv_blk_start[i] = blk_start[i];
				sv_blk_req[i] = blk_req[i];
				sv_blk_len[i] = blk_len[i];
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (back) cnt[i] = sv_cnt[i];
			else sv_cnt[i] = cnt[i];
		end
		if (back) begin
			ext_n = sv_ext_n;
			blk_n = sv_blk_n;
		end else begin
			sv_ext_n = ext_n;
			sv_blk_n = blk_n;
		end
	endfunction

	function automatic void count_fail(logic [31:0] size);
		cnt[CNT_FAIL] = sat_add(cnt[CNT_FAIL], 1, M32);
		cnt[CNT_FBYTES] = sat_add(cnt[CNT_FBYTES], {32'd0, size}, M48);
	endfunction

	function automatic int find_block(logic [47:0] a);
		for (int i = 0; i < blk_n; i++)
			if (blk_start[i] == a) return i;
		return -1;
	endfunction

	function automatic void drop_block(int i);
		int last;
		last = blk_n - 1;
		blk_start[i] = blk_start[last];
		blk_req[i] = blk_req[last];
		blk_len[i] = blk_len[last];
		blk_n = last;
	endfunction

	function automatic void drop_extent(int j);
		for (int k = j; k + 1 < ext_n; k++) begin
			ext_start[k] = ext_start[k + 1];
			ext_len[k] = ext_len[k + 1];
		end
		ext_n--;
	endfunction

	// return a range to the free list, merging with touching extents
	function automatic logic [2:0] give_back(logic [47:0] start, logic [31:0] len);
		logic [63:0] o;
		int i;
		bit mp, mn;
		o = heap_off(start);
		i = 0;
		while (i < ext_n && heap_off(ext_start[i]) <= o) i++;
		mp = i > 0 && heap_off(ext_start[i - 1]) + ext_len[i - 1] == o;
		mn = i < ext_n && o + len == heap_off(ext_start[i]);
		if (mp && mn) begin
			ext_len[i - 1] = ext_len[i - 1] + len + ext_len[i];
			drop_extent(i);
		end else if (mp) begin
			ext_len[i - 1] = ext_len[i - 1] + len;
		end else if (mn) begin
			ext_start[i] = start;
			ext_len[i] = ext_len[i] + len;
		end else begin
			if (ext_n >= NFREE) return ST_FULL;
			for (int j = ext_n; j > i; j--) begin
				ext_start[j] = ext_start[j - 1];
				ext_len[j] = ext_len[j - 1];
			end
			ext_start[i] = start;
			ext_len[i] = len;
			ext_n++;
		end
		return ST_OK;
	endfunction

	function automatic logic [63:0] round_block(logic [31:0] size);
		return ({32'd0, size} / ALIGN + 1) * ALIGN;
	endfunction

	function automatic logic [2:0] grant(logic [31:0] size, output logic [47:0] got);
		logic [63:0] blk, fin;
		logic [47:0] a;
		int j, k;
		got = '0;
		if (size >= HEAP) begin
			count_fail(size);
			return ST_TOO_BIG;
		end
		if (blk_n >= NLIVE) begin
			count_fail(size);
			return ST_FULL;
		end
		blk = round_block(size);
		for (j = 0; j < ext_n; j++)
			if (ext_len[j] >= blk) break;
		if (j >= ext_n) begin
			count_fail(size);
			return ST_NO_SPACE;
		end
		a = ext_start[j];
		if (ext_len[j] > blk) begin
			ext_start[j] = a + blk[47:0];
			ext_len[j] = ext_len[j] - blk[31:0];
		end else begin
			drop_extent(j);
		end
		k = blk_n;
		blk_n++;
		blk_start[k] = a;
		blk_req[k] = size;
		blk_len[k] = blk[31:0];
		cnt[CNT_TOTAL] = sat_add(cnt[CNT_TOTAL], 1, M32);
		cnt[CNT_TBYTES] = sat_add(cnt[CNT_TBYTES], {32'd0, size}, M48);
		cnt[CNT_LIVE]++;
		cnt[CNT_LBYTES] += size;
		if ({16'd0, a} < cnt[CNT_LOW]) cnt[CNT_LOW] = {16'd0, a};
		fin = sat_add({16'd0, a}, {32'd0, size}, M48);
		if (fin > cnt[CNT_HIGH]) cnt[CNT_HIGH] = fin;
		got = a;
		return ST_OK;
	endfunction

	function automatic logic [2:0] release_block(logic [47:0] a);
		int i;
		logic [2:0] st;
		if (a == 0) return ST_OK;
		for (int j = 0; j < ext_n; j++)
			if (ext_start[j] == a) return ST_DBL_FREE;
		if (heap_off(a) >= HEAP) return ST_OUTSIDE;
		i = find_block(a);
		if (i < 0) return ST_NOT_ALLOC;
		st = give_back(blk_start[i], blk_len[i]);
		if (st != ST_OK) return st;
		cnt[CNT_LIVE]--;
		cnt[CNT_LBYTES] -= blk_req[i];
		drop_block(i);
		return ST_OK;
	endfunction

	function automatic logic [2:0] regrant(logic [47:0] a, logic [31:0] size,
			output logic [47:0] got);
		int i;
		logic [31:0] oldreq, oldblk;
		logic [63:0] blk;
		logic [47:0] na;
		logic [2:0] st;
		got = '0;
		if (size == 0) return release_block(a);
		if (a == 0) return grant(size, got);
		i = find_block(a);
		if (i < 0) return ST_NOT_ALLOC;
		oldreq = blk_req[i];
		oldblk = blk_len[i];
		blk = round_block(size);
		if (blk <= oldblk) begin
			if (blk < oldblk && give_back(a + blk[47:0], oldblk - blk[31:0]) != ST_OK)
				return ST_FULL;
			blk_len[i] = blk[31:0];
			blk_req[i] = size;
			cnt[CNT_LBYTES] = cnt[CNT_LBYTES] - oldreq + size;
			got = a;
			return ST_OK;
		end
		snapshot(0);
		st = grant(size, na);
		if (st != ST_OK) return st;
		if (give_back(a, oldblk) != ST_OK) begin
			snapshot(1);
			count_fail(size);
			return ST_FULL;
		end
		cnt[CNT_LIVE]--;
		cnt[CNT_LBYTES] -= oldreq;
		drop_block(i);
		got = na;
		return ST_OK;
	endfunction

	function automatic rsp_t predict_result(req_t r);
		rsp_t e;
		logic [2:0] st;
		logic [47:0] got;
		got = '0;
		st = ST_OK;
		case (r.cmd)
			CMD_ALLOC:  st = grant(r.size, got);
			CMD_FREE:   st = release_block(r.addr);
			CMD_RESIZE: st = regrant(r.addr, r.size, got);
			default:    st = ST_OK;
		endcase
		if (st != ST_OK) got = '0;
		e.status = st;
		e.result_addr = got;
		e.live_allocs = cnt[CNT_LIVE][31:0];
		e.live_bytes = cnt[CNT_LBYTES][47:0];
		e.total_allocs = cnt[CNT_TOTAL][31:0];
		e.total_bytes = cnt[CNT_TBYTES][47:0];
		e.failed_allocs = cnt[CNT_FAIL][31:0];
		e.failed_bytes = cnt[CNT_FBYTES][47:0];
		e.lowest_addr = cnt[CNT_LOW][47:0];
		e.highest_end = cnt[CNT_HIGH][47:0];
		return e;
	endfunction

	function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			n_errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, e, a);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			n_errors <= 0;
			expected_rsp.delete();
			heap_base = HEAP_BASE_RST;
			reload_tables();
			for (int i = 0; i < 8; i++) cnt[i] = '0;
			cnt[CNT_LOW] = M48;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					n_errors++;
					$display("%0t: result transfer with nothing expected, got %p", $time, rsp);
				end else begin
					e = expected_rsp.pop_front();
					check_field("status", e.status, rsp.status);
					check_field("result_addr", e.result_addr, rsp.result_addr);
					check_field("live_allocs", e.live_allocs, rsp.live_allocs);
					check_field("live_bytes", e.live_bytes, rsp.live_bytes);
					check_field("total_allocs", e.total_allocs, rsp.total_allocs);
					check_field("total_bytes", e.total_bytes, rsp.total_bytes);
					check_field("failed_allocs", e.failed_allocs, rsp.failed_allocs);
					check_field("failed_bytes", e.failed_bytes, rsp.failed_bytes);
					check_field("lowest_addr", e.lowest_addr, rsp.lowest_addr);
					check_field("highest_end", e.highest_end, rsp.highest_end);
				end
			end
			if (req_valid && req_ready)
				expected_rsp.push_back(predict_result(req));
			if (psel && penable && pwrite && pready && paddr[3] == REG_HEAP_BASE) begin
				heap_base = pwdata[47:0];
				reload_tables();
			end
		end
	end

endmodule

>>> sim/tb_first_fit_extent_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_extent_allocator_top
// Stimulus and verdict for the extent allocator: directed corner requests,
// then random allocate/free/resize traffic over several heap bases, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_first_fit_extent_allocator_top;
	import ffea_pkg::*;

	localparam int HEAP = HEAP_BYTES_DEF;
	localparam int LIMIT = 5_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	int          n_errors, n_pending;
	int          n_sent = 0;
	int          n_recv = 0;
	int          n_cycles = 0;
	int          rsp_hold = 0;
	bit          calm = 0;
	logic [47:0] cur_base = HEAP_BASE_RST;
	logic [47:0] granted[$];

	first_fit_extent_allocator_top dut (.*);

	ffea_checker chk (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .n_errors, .n_pending
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > LIMIT) begin
			$display("first_fit_extent_allocator_top: mismatch");
			$finish;
		end
	end

	// result side: after each transfer, stall rsp_ready at random unless calm
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			n_recv <= n_recv + 1;
			if (rsp.status == ST_OK && rsp.result_addr != 0) begin
				granted.push_back(rsp.result_addr);
				if (granted.size() > 96) void'(granted.pop_front());
			end
			rsp_hold = calm ? 0 : $urandom_range(0, 14);
		end
		if (rsp_hold > 0) begin
			rsp_ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic send(logic [1:0] c, logic [47:0] a, logic [31:0] s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: c, addr: a, size: s};
		do @(posedge clk); while (!req_ready);
		n_sent++;
	endtask

	task automatic write_base(logic [47:0] v);
		req_valid <= 1'b0;
		while (n_recv != n_sent) @(posedge clk);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 4'd0;
		pwdata <= {16'd0, v};
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_base = v;
		@(posedge clk);
	endtask

	function automatic logic [47:0] pick_addr();
		if (granted.size() == 0) return cur_base;
		return granted[$urandom_range(0, granted.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(0, 3000);
		if (r < 92) return $urandom_range(0, HEAP + 64);
		return $urandom;
	endfunction

	task automatic random_item();
		int r;
		logic [47:0] a;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			// fill the live table to its limit
			repeat (70) send(CMD_ALLOC, '0, $urandom_range(0, 200));
		end else if (r < 5) begin
			// shrink many blocks to fragment the free list
			foreach (granted[i]) send(CMD_RESIZE, granted[i], $urandom_range(0, 8));
		end else if (r < 33) begin
			send(CMD_ALLOC, 48'({$urandom, $urandom}), pick_size());
		end else if (r < 58) begin
			send(CMD_FREE, pick_addr(), $urandom);
		end else if (r < 78) begin
			send(CMD_RESIZE, pick_addr(), ($urandom_range(0, 9) == 0) ? 32'd0 : pick_size());
		end else if (r < 82) begin
			send(CMD_RESIZE, '0, $urandom_range(1, 3000));
		end else begin
			case ($urandom_range(0, 3))
				0: a = 48'({$urandom, $urandom});
				1: a = cur_base + HEAP;
				2: a = pick_addr() + 16;
				default: a = '0;
			endcase
			send(2'($urandom_range(0, 3)), a, $urandom);
		end
	endtask

	initial begin
		logic [47:0] bases[3];
		int phases;
		bases[0] = 48'hFFFF_FFFF_FFFF;
		bases[1] = 48'({$urandom, $urandom}) | 48'h1000;
		bases[2] = 48'd4096;
		phases = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed corners at the reset base
		send(CMD_ALLOC, '0, 32'd0);
		send(CMD_ALLOC, '0, 32'd15);
		send(CMD_ALLOC, '0, 32'd16);
		send(CMD_ALLOC, '0, HEAP - 1);
		send(CMD_ALLOC, '0, HEAP);
		send(CMD_ALLOC, '0, 32'hFFFF_FFFF);
		send(CMD_FREE, '0, '0);
		send(CMD_FREE, 48'd4096, '0);
		send(CMD_FREE, 48'd4096, '0);
		send(CMD_FREE, 48'd4096 + HEAP, '0);
		send(CMD_FREE, 48'hFFFF_FFFF_FFFF, '0);
		send(CMD_FREE, 48'd4104, '0);
		send(CMD_RESIZE, '0, 32'd100);
		send(CMD_RESIZE, 48'd4112, 32'd0);
		send(CMD_RESIZE, 48'd4128, 32'd1);
		send(CMD_RESIZE, 48'd4128, 32'd5000);
		send(CMD_RESIZE, 48'd4136, 32'd10);
		send(CMD_RESIZE, 48'd4096, HEAP);
		send(2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);

		while (n_sent < 200) begin
			calm = ($urandom_range(0, 19) == 0) ? !calm : calm;
			random_item();
		end
		foreach (bases[p]) begin
			calm = 0;
			write_base(bases[p]);
			phases++;
			while (n_sent < 200 * (p + 2)) begin
				calm = ($urandom_range(0, 19) == 0) ? !calm : calm;
				random_item();
			end
		end

		req_valid <= 1'b0;
		while (n_pending != 0 || n_recv != n_sent) @(posedge clk);
		repeat (700) @(posedge clk);
		$display("covered %0d requests over %0d heap bases, %0d results compared",
			n_sent, phases, n_recv);
		if (n_errors == 0 && n_pending == 0) begin
			$display("first_fit_extent_allocator_top: match");
		end else begin
			$display("first_fit_extent_allocator_top: mismatch");
		end
		$finish;
	end

endmodule
